// ===== rtl/core/chi_pkg.sv =====
`timescale 1ns / 1ps
package chi_pkg;

	localparam int NUM_BINS   = 255;
	localparam int BIN_CENTER = 127;

	localparam logic [1:0] FUNC_ADD   = 2'd0;
	localparam logic [1:0] FUNC_READ  = 2'd1;
	localparam logic [1:0] FUNC_CLEAR = 2'd2;
	localparam logic [1:0] FUNC_NOP   = 2'd3;

	typedef struct packed {
		logic [1:0] func;
		logic [6:0] pitch;
		logic       chord_start;
		logic [7:0] bin_index;
	} req_t;

	typedef struct packed {
		logic [31:0] bin_count;
		logic [4:0]  pairs_added;
		logic        note_dropped;
	} rsp_t;

	typedef enum logic [1:0] {
		OP_ADD,
		OP_READ,
		OP_CLEAR,
		OP_NOP
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [6:0] pitch;
		logic       chord_start;
		logic [7:0] bin_index;
		logic       in_range;
	} job_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_RUN,
		B_DRAIN,
		B_READ
	} back_state_t;

endpackage

// ===== rtl/core/chi_ram.sv =====
`timescale 1ns / 1ps
module chi_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// read returns the old word when the same address is written
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/core/chi_front.sv =====
`timescale 1ns / 1ps
module chi_front (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  chi_pkg::req_t req,
	output logic         busy,
	output logic         job_vld,
	output chi_pkg::job_t job,
	input  logic         pop
);
	import chi_pkg::*;

	job_t       ent_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       push;
	job_t       new_job;

	always_comb begin
		new_job.pitch       = req.pitch;
		new_job.chord_start = req.chord_start;
		new_job.bin_index   = req.bin_index;
		new_job.in_range    = (req.bin_index < 8'(NUM_BINS));
		case (req.func)
			FUNC_ADD:   new_job.op = OP_ADD;
			FUNC_READ:  new_job.op = OP_READ;
			FUNC_CLEAR: new_job.op = OP_CLEAR;
			default:    new_job.op = OP_NOP;
		endcase
	end

	assign busy    = cnt_q[1];
	assign push    = start && !busy;
	assign job_vld = (cnt_q != 2'd0);
	assign job     = ent_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= new_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop && job_vld) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop && job_vld);
		end
	end

endmodule

// ===== rtl/core/chi_back.sv =====
`timescale 1ns / 1ps
module chi_back #(
	parameter int MAX_CHORD  = 16,
	parameter int COUNT_BITS = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          job_vld,
	input  chi_pkg::job_t job,
	output logic          pop,
	output logic          done,
	output chi_pkg::rsp_t rsp
);
	import chi_pkg::*;

	localparam int CW = (MAX_CHORD > 1) ? $clog2(MAX_CHORD) : 1;
	localparam int SW = $clog2(MAX_CHORD + 1);
	localparam int CD = 2 * (1 << CW);

	back_state_t            state_q, state_d;
	logic                   bank_q;
	logic [SW-1:0]          cur_size_q;
	logic [SW-1:0]          prev_size_q;
	logic [SW-1:0]          k_q;
	logic [6:0]             note_q;
	logic                   vld_s1, vld_s2;
	logic [7:0]             bin_s2;
	logic                   wr_vld_q;
	logic [7:0]             wr_bin_q;
	logic [COUNT_BITS-1:0]  wr_val_q;
	logic [NUM_BINS-1:0]    bin_vld_q;
	logic                   rd_ok_q;
	logic [7:0]             rd_bin_q;
	logic                   done_q;
	rsp_t                   rsp_q;

	logic                   done_d;
	rsp_t                   rsp_d;
	logic                   eff_bank;
	logic [SW-1:0]          eff_prev, eff_cur;
	logic                   full;
	logic                   chord_we;
	logic [CW:0]            chord_waddr, chord_raddr;
	logic [6:0]             chord_rdata;
	logic [7:0]             bin_s1;
	logic [7:0]             cnt_raddr;
	logic [COUNT_BITS-1:0]  cnt_rdata, old_val, new_val, rd_val;
	logic [63:0]            rd_wide;

	chi_ram #(.WIDTH(7), .DEPTH(CD)) u_chord_ram (
		.clk   (clk),
		.we    (chord_we),
		.waddr (chord_waddr),
		.wdata (job.pitch),
		.raddr (chord_raddr),
		.rdata (chord_rdata)
	);

	chi_ram #(.WIDTH(COUNT_BITS), .DEPTH(NUM_BINS)) u_count_ram (
		.clk   (clk),
		.we    (vld_s2),
		.waddr (bin_s2),
		.wdata (new_val),
		.raddr (cnt_raddr),
		.rdata (cnt_rdata)
	);

	assign eff_bank = job.chord_start ? ~bank_q : bank_q;
	assign eff_prev = job.chord_start ? cur_size_q : prev_size_q;
	assign eff_cur  = job.chord_start ? '0 : cur_size_q;
	assign full     = (eff_cur >= SW'(MAX_CHORD));
	assign bin_s1   = 8'(BIN_CENTER) + {1'b0, note_q} - {1'b0, chord_rdata};

	// the write of the preceding pair is not yet seen by the read port
	assign old_val = (wr_vld_q && wr_bin_q == bin_s2) ? wr_val_q
		: (bin_vld_q[bin_s2] ? cnt_rdata : '0);
	assign new_val = (&old_val) ? old_val : old_val + 1'b1;

	assign rd_val  = (rd_ok_q && bin_vld_q[rd_bin_q]) ? cnt_rdata : '0;
	assign rd_wide = 64'(rd_val);

	always_comb begin
		state_d     = state_q;
		pop         = 1'b0;
		chord_we    = 1'b0;
		chord_waddr = {eff_bank, eff_cur[CW-1:0]};
		chord_raddr = {~bank_q, k_q[CW-1:0]};
		cnt_raddr   = bin_s1;
		done_d      = 1'b0;
		rsp_d       = '0;
		case (state_q)
			B_IDLE: begin
				cnt_raddr = job.bin_index;
				if (job_vld) begin
					pop = 1'b1;
					case (job.op)
						OP_ADD: begin
							if (full) begin
								done_d             = 1'b1;
								rsp_d.note_dropped = 1'b1;
							end else begin
								chord_we = 1'b1;
								if (eff_prev == '0) begin
									done_d = 1'b1;
								end else begin
									state_d = B_RUN;
								end
							end
						end
						OP_READ: state_d = B_READ;
						default: done_d = 1'b1;
					endcase
				end
			end
			B_RUN: begin
				if (k_q == prev_size_q - 1'b1) begin
					state_d = B_DRAIN;
				end
			end
			B_DRAIN: begin
				if (!vld_s1 && !vld_s2) begin
					done_d            = 1'b1;
					rsp_d.pairs_added = 5'(prev_size_q);
					state_d           = B_IDLE;
				end
			end
			B_READ: begin
				done_d          = 1'b1;
				rsp_d.bin_count = (rd_wide > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : rd_wide[31:0];
				state_d         = B_IDLE;
			end
			default: state_d = B_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		bin_s2   <= bin_s1;
		wr_bin_q <= bin_s2;
		wr_val_q <= new_val;
		rsp_q    <= rsp_d;
		if (state_q == B_IDLE && job_vld) begin
			note_q   <= job.pitch;
			rd_bin_q <= job.bin_index;
			rd_ok_q  <= job.in_range;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			bank_q      <= 1'b0;
			cur_size_q  <= '0;
			prev_size_q <= '0;
			k_q         <= '0;
			vld_s1      <= 1'b0;
			vld_s2      <= 1'b0;
			wr_vld_q    <= 1'b0;
			bin_vld_q   <= '0;
			done_q      <= 1'b0;
		end else begin
			state_q  <= state_d;
			done_q   <= done_d;
			vld_s1   <= (state_q == B_RUN);
			vld_s2   <= vld_s1;
			wr_vld_q <= vld_s2;
			if (vld_s2) begin
				bin_vld_q[bin_s2] <= 1'b1;
			end
			if (state_q == B_RUN) begin
				k_q <= k_q + 1'b1;
			end
			if (state_q == B_IDLE && job_vld) begin
				case (job.op)
					OP_ADD: begin
						bank_q      <= eff_bank;
						prev_size_q <= eff_prev;
						cur_size_q  <= full ? eff_cur : eff_cur + 1'b1;
						k_q         <= '0;
					end
					OP_CLEAR: begin
						bin_vld_q   <= '0;
						cur_size_q  <= '0;
						prev_size_q <= '0;
					end
					default: ;
				endcase
			end
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

	a_run_in_chord: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_RUN) |-> (k_q < prev_size_q))
		else $error("chord read index past previous chord");
	a_size_cap: assert property (@(posedge clk) disable iff (!arst_n)
		(cur_size_q <= SW'(MAX_CHORD)) && (prev_size_q <= SW'(MAX_CHORD)))
		else $error("chord size above capacity");
	a_drop_no_pairs: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.note_dropped) |-> (rsp.pairs_added == 5'd0))
		else $error("dropped note reports pairs");
	a_one_field: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (rsp.bin_count == 32'd0 || (rsp.pairs_added == 5'd0 && !rsp.note_dropped)))
		else $error("read and add fields both set");
	a_write_follows: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 |-> $past(state_q == B_RUN, 2))
		else $error("count write without issued pair");

endmodule

// ===== rtl/core/chord_interval_histogram.sv =====
`timescale 1ns / 1ps
// chord interval histogram
// requests enter on start/req when busy is low; busy rises when the
// two-entry request queue is full. func add stores a note in the current
// chord and bumps one interval bin per note of the previous chord; read
// returns one bin; clear empties all bins and both chords.
// each request gives exactly one result on rsp, marked by done for one
// cycle; the receiver cannot stall, so results are never held back.
// after a request leaves the queue, clear, nop, dropped and pair-free
// notes give their result straight from idle; a read passes through the
// read state; a note with previous-chord notes runs one count
// read-modify-write per pair, then drains the pipeline before its result.
// the back end takes the next request in the cycle a result is issued,
// so it works on one request at a time; a request is registered in the
// queue before it can be taken.
// reset empties the queue, both chords and all bins (bins through one
// valid flag each, so no clearing pass is needed) and the block is ready
// in the first cycle after reset.
module chord_interval_histogram #(
	parameter int MAX_CHORD  = 16,
	parameter int COUNT_BITS = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  chi_pkg::req_t req,
	output logic          busy,
	output logic          done,
	output chi_pkg::rsp_t rsp
);
	import chi_pkg::*;

	logic job_vld;
	job_t job;
	logic pop;

	chi_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.req     (req),
		.busy    (busy),
		.job_vld (job_vld),
		.job     (job),
		.pop     (pop)
	);

	chi_back #(.MAX_CHORD(MAX_CHORD), .COUNT_BITS(COUNT_BITS)) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.job_vld (job_vld),
		.job     (job),
		.pop     (pop),
		.done    (done),
		.rsp     (rsp)
	);

endmodule

// ===== tb/chord_interval_histogram_tb.sv =====
`timescale 1ns / 1ps
module chord_interval_histogram_tb;
	import chi_pkg::*;

	localparam int MAX_NOTES = 16;
	localparam int CYCLE_LIMIT = 400000;

	logic  clk;
	logic  arst_n;
	logic  start;
	req_t  req;
	logic  busy;
	logic  done;
	rsp_t  rsp;

	chord_interval_histogram u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .req(req),
		.busy(busy), .done(done), .rsp(rsp)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// predictor state
	logic [31:0] hist_bins [NUM_BINS];
	logic [6:0]  prev_notes [MAX_NOTES];
	logic [6:0]  cur_notes [MAX_NOTES];
	int          prev_len;
	int          cur_len;
	rsp_t        expected_rsps [$];
	int          send_gap_pct;
	int          errors;
	int          cycles;

	task automatic clear_histogram();
		for (int i = 0; i < NUM_BINS; i++) hist_bins[i] = '0;
		prev_len = 0;
		cur_len = 0;
	endtask

	function automatic rsp_t predict_request(req_t r);
		rsp_t o;
		int   b;
		o = '0;
		case (r.func)
			FUNC_ADD: begin
				if (r.chord_start) begin
					prev_notes = cur_notes;
					prev_len = cur_len;
					cur_len = 0;
				end
				if (cur_len >= MAX_NOTES) begin
					o.note_dropped = 1'b1;
				end else begin
					for (int k = 0; k < prev_len; k++) begin
						b = BIN_CENTER + int'(r.pitch) - int'(prev_notes[k]);
						if (hist_bins[b] != '1) hist_bins[b] = hist_bins[b] + 1;
					end
					o.pairs_added = 5'(prev_len);
					cur_notes[cur_len] = r.pitch;
					cur_len++;
				end
			end
			FUNC_READ: begin
				if (r.bin_index < NUM_BINS) o.bin_count = hist_bins[r.bin_index];
			end
			FUNC_CLEAR: begin
				for (int i = 0; i < NUM_BINS; i++) hist_bins[i] = '0;
				prev_len = 0;
				cur_len = 0;
			end
			default: ;
		endcase
		return o;
	endfunction

	// start stays high between back-to-back requests and drops only while idling
	task automatic send_request(req_t r);
		while ($urandom_range(99, 0) < send_gap_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		req <= r;
		@(posedge clk);
		while (busy) @(posedge clk);
		expected_rsps.push_back(predict_request(r));
	endtask

	task automatic send_fields(logic [1:0] f, logic [6:0] p, logic s, logic [7:0] idx);
		req_t r;
		r.func = f;
		r.pitch = p;
		r.chord_start = s;
		r.bin_index = idx;
		send_request(r);
	endtask

	// result checker
	always @(posedge clk) begin
		rsp_t e;
		if (arst_n && done) begin
			if (expected_rsps.size() == 0) begin
				$display("%0t: unexpected result %h", $time, rsp);
				errors++;
			end else begin
				e = expected_rsps.pop_front();
				if (rsp.bin_count !== e.bin_count) begin
					$display("%0t: bin_count exp %0d got %0d", $time, e.bin_count,
						rsp.bin_count);
					errors++;
				end
				if (rsp.pairs_added !== e.pairs_added) begin
					$display("%0t: pairs_added exp %0d got %0d", $time, e.pairs_added,
						rsp.pairs_added);
					errors++;
				end
				if (rsp.note_dropped !== e.note_dropped) begin
					$display("%0t: note_dropped exp %0b got %0b", $time, e.note_dropped,
						rsp.note_dropped);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic test_directed();
		send_fields(FUNC_READ, 7'd0, 1'b0, 8'd127);
		// notes before any chord start count nothing
		send_fields(FUNC_ADD, 7'd60, 1'b0, 8'd0);
		send_fields(FUNC_ADD, 7'd0, 1'b0, 8'd255);
		send_fields(FUNC_ADD, 7'd127, 1'b1, 8'd0);
		send_fields(FUNC_ADD, 7'd0, 1'b0, 8'd0);
		send_fields(FUNC_ADD, 7'd127, 1'b1, 8'd0);
		send_fields(FUNC_READ, 7'd0, 1'b0, 8'd0);
		send_fields(FUNC_READ, 7'd0, 1'b0, 8'd254);
		send_fields(FUNC_READ, 7'd0, 1'b0, 8'd127);
		send_fields(FUNC_READ, 7'd127, 1'b1, 8'd255);
		send_fields(FUNC_NOP, 7'd127, 1'b1, 8'd255);
		// overfill one chord to force drops
		for (int i = 0; i < MAX_NOTES + 2; i++)
			send_fields(FUNC_ADD, 7'(i * 7), i == 0, 8'd0);
		send_fields(FUNC_ADD, 7'd64, 1'b1, 8'd0);
		send_fields(FUNC_READ, 7'd0, 1'b0, 8'd127 + 8'd64 - 8'd0);
		send_fields(FUNC_CLEAR, 7'd0, 1'b0, 8'd0);
		send_fields(FUNC_READ, 7'd0, 1'b0, 8'd191);
	endtask

	task automatic test_random(int n);
		int   left;
		int   chord_len;
		logic [6:0] base;
		req_t r;
		left = n;
		while (left > 0) begin
			if ($urandom_range(9, 0) < 8) begin
				// a chord of random size around a base pitch
				chord_len = ($urandom_range(9, 0) == 0) ? $urandom_range(20, 15)
					: $urandom_range(5, 1);
				base = 7'($urandom_range(127, 0));
				for (int k = 0; k < chord_len; k++) begin
					r = req_t'($urandom);
					r.func = FUNC_ADD;
					r.chord_start = (k == 0);
					if ($urandom_range(3, 0) != 0) r.pitch = base + 7'($urandom_range(12, 0));
					send_request(r);
					left--;
				end
			end else begin
				r = req_t'($urandom);
				if (r.func == FUNC_CLEAR && $urandom_range(3, 0) != 0) r.func = FUNC_READ;
				if (r.func == FUNC_READ && $urandom_range(1, 0) == 0)
					r.bin_index = 8'(BIN_CENTER) + 8'($urandom_range(24, 0)) - 8'd12;
				send_request(r);
				left--;
			end
		end
	endtask

	initial begin
		errors = 0;
		cycles = 0;
		send_gap_pct = 10;
		start = 1'b0;
		req = '0;
		clear_histogram();
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(130);
		send_gap_pct = 51;
		test_random(130);
		send_gap_pct = 0;
		test_random(140);
		start <= 1'b0;
		while (expected_rsps.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (errors == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/chi_pkg.sv
rtl/core/chi_ram.sv
rtl/core/chi_front.sv
rtl/core/chi_back.sv
rtl/core/chord_interval_histogram.sv
tb/chord_interval_histogram_tb.sv
